/* rtl/h2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2d_pkg
// Shared types and constants for the 2D histogram binning accumulator.
// ----------------------------------------------------------------------------
package h2d_pkg;

  localparam int H2D_BINS_X = 64;
  localparam int H2D_BINS_Y = 64;

  localparam int BIN_W  = 48;
  localparam int CFG_AW = 5;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_MASS   = 3'd1;
  localparam logic [2:0] REG_INV_X  = 3'd2;
  localparam logic [2:0] REG_INV_Y  = 3'd3;
  localparam logic [2:0] REG_LOW_X  = 3'd4;
  localparam logic [2:0] REG_LOW_Y  = 3'd5;
  localparam logic [2:0] REG_WEIGHT = 3'd6;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] comp_a;
    logic signed [31:0] comp_b;
    logic signed [31:0] comp_c;
  } h2d_in_t;

  typedef struct packed {
    logic             in_window;
    logic [BIN_W-1:0] bin_value;
    logic             last_bin;
  } h2d_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_INDEX,
    ST_WINDOW,
    ST_FETCH,
    ST_UPDATE,
    ST_DONE
  } h2d_state_t;

endpackage
`default_nettype wire

/* rtl/h2d_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module h2d_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/histogram_2d_binning_accumulator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_2d_binning_accumulator
// Bins particles into a 2D histogram held in one RAM; read requests drain
// and clear the histogram bin by bin.
// ----------------------------------------------------------------------------
// Sequence: a read request fetches, returns and clears one bin; a
//   position-mode accumulate scales, checks the window and, on a hit,
//   does the read-modify-write; velocity mode first squares m, px, py, pz,
//   runs 32 square-root steps and 2 x 47 divide steps, then does the same.
// Throughput: one request at a time; the next is taken once the result is in
//   the output register, and a held result stalls the one after it. The shared
//   32x32 multiplier, the one-bit-per-cycle root and divider slow velocity mode.
// Reset: control and configuration registers return to defaults, then a
//   clearing pass writes zero to all BINS_X*BINS_Y bins with in_ready low.
module histogram_2d_binning_accumulator
  import h2d_pkg::*;
#(
  parameter int BINS_X = H2D_BINS_X,
  parameter int BINS_Y = H2D_BINS_Y
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire h2d_in_t           in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output h2d_out_t               out_data,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int NUM_BINS = BINS_X * BINS_Y;
  localparam int AW       = $clog2(NUM_BINS);
  localparam int XW       = $clog2(BINS_X);
  localparam int YW       = $clog2(BINS_Y);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic               projection_mode;
  logic [31:0]        rest_mass;
  logic [31:0]        inv_bin_width_x;
  logic [31:0]        inv_bin_width_y;
  logic signed [15:0] bin_low_x;
  logic signed [15:0] bin_low_y;
  logic [31:0]        particle_weight;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      projection_mode <= 1'b0;
      rest_mass       <= 32'h0001_0000;
      inv_bin_width_x <= 32'h0001_0000;
      inv_bin_width_y <= 32'h0001_0000;
      bin_low_x       <= -16'sd32;
      bin_low_y       <= -16'sd32;
      particle_weight <= 32'h0001_0000;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MODE:   projection_mode <= pwdata[0];
        REG_MASS:   rest_mass       <= pwdata;
        REG_INV_X:  inv_bin_width_x <= pwdata;
        REG_INV_Y:  inv_bin_width_y <= pwdata;
        REG_LOW_X:  bin_low_x       <= pwdata[15:0];
        REG_LOW_Y:  bin_low_y       <= pwdata[15:0];
        REG_WEIGHT: particle_weight <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MODE:   prdata = {31'd0, projection_mode};
      REG_MASS:   prdata = rest_mass;
      REG_INV_X:  prdata = inv_bin_width_x;
      REG_INV_Y:  prdata = inv_bin_width_y;
      REG_LOW_X:  prdata = {{16{bin_low_x[15]}}, bin_low_x};
      REG_LOW_Y:  prdata = {{16{bin_low_y[15]}}, bin_low_y};
      REG_WEIGHT: prdata = particle_weight;
      default:    prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  h2d_state_t        state, state_next;
  logic [2:0]        cnt, cnt_next;          // squaring / index steps
  logic [5:0]        step, step_next;        // sqrt / divide steps
  logic              is_read, is_read_next;
  logic [31:0]       mag_x, mag_x_next;      // |projection| or |px|
  logic [31:0]       mag_y, mag_y_next;
  logic [31:0]       mag_c, mag_c_next;
  logic              sign_x, sign_x_next;
  logic              sign_y, sign_y_next;
  logic [63:0]       prod;                   // shared multiplier output
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       sq_x, sq_x_next;        // sum of squares, sqrt remainder
  logic [63:0]       sq_r, sq_r_next;        // sqrt root
  logic [63:0]       sq_bit, sq_bit_next;
  logic [31:0]       energy, energy_next;
  logic [46:0]       dv_num, dv_num_next;
  logic [31:0]       dv_rem, dv_rem_next;
  logic [46:0]       dv_q, dv_q_next;
  logic              dv_sel, dv_sel_next;    // 0 divides px, 1 divides py
  logic [31:0]       idx_x, idx_x_next;
  logic [31:0]       idx_y, idx_y_next;
  logic [AW-1:0]     addr, addr_next;
  logic [AW-1:0]     clr_cnt, clr_cnt_next;
  logic [XW-1:0]     rd_x, rd_x_next;
  logic [YW-1:0]     rd_y, rd_y_next;
  h2d_out_t          res, res_next;
  h2d_out_t          out_next;
  logic              out_valid_next;

  // RAM port signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BIN_W-1:0]  ram_wdata;
  logic [BIN_W-1:0]  ram_rdata;

  // step helpers
  logic [63:0]        sq_trial;
  logic [32:0]        dv_trial;
  logic               dv_ge;
  logic [46:0]        dv_q_fin;
  logic [31:0]        vel_mag;
  logic [31:0]        idx_new;
  logic signed [33:0] ix, iy, ox, oy;
  logic               hit;
  logic [BIN_W:0]     bin_sum;

  // Shared multiplier: one 32x32 product per cycle, registered.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    mul_a = mag_x;
    mul_b = inv_bin_width_x;
    if (state == ST_SQUARE) begin
      case (cnt)
        3'd0:    mul_a = rest_mass;
        3'd1:    mul_a = mag_x;
        3'd2:    mul_a = mag_y;
        default: mul_a = mag_c;
      endcase
      mul_b = mul_a;
    end else if (cnt != 3'd0) begin
      mul_a = mag_y;
      mul_b = inv_bin_width_y;
    end
  end

  assign sq_trial = sq_r + sq_bit;
  assign dv_trial = {dv_rem, dv_num[46]};
  assign dv_ge    = dv_trial >= {1'b0, energy};
  assign dv_q_fin = {dv_q[45:0], dv_ge};
  assign vel_mag  = (energy == 32'd0) ? 32'd0 :
                    (dv_q_fin > 47'h0_8000_0000) ? 32'h8000_0000 : dv_q_fin[31:0];
  assign idx_new  = 32'((prod + 64'h0000_0000_8000_0000) >> 32);

  assign ix  = sign_x ? -$signed({2'b00, idx_x}) : $signed({2'b00, idx_x});
  assign iy  = sign_y ? -$signed({2'b00, idx_y}) : $signed({2'b00, idx_y});
  assign ox  = ix - 34'(bin_low_x);
  assign oy  = iy - 34'(bin_low_y);
  assign hit = (ox > 34'sd0) && (ox < 34'(BINS_X)) &&
               (oy > 34'sd0) && (oy < 34'(BINS_Y));

  assign bin_sum = {1'b0, ram_rdata} + (BIN_W+1)'(particle_weight);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    step_next      = step;
    is_read_next   = is_read;
    mag_x_next     = mag_x;
    mag_y_next     = mag_y;
    mag_c_next     = mag_c;
    sign_x_next    = sign_x;
    sign_y_next    = sign_y;
    sq_x_next      = sq_x;
    sq_r_next      = sq_r;
    sq_bit_next    = sq_bit;
    energy_next    = energy;
    dv_num_next    = dv_num;
    dv_rem_next    = dv_rem;
    dv_q_next      = dv_q;
    dv_sel_next    = dv_sel;
    idx_x_next     = idx_x;
    idx_y_next     = idx_y;
    addr_next      = addr;
    clr_cnt_next   = clr_cnt;
    rd_x_next      = rd_x;
    rd_y_next      = rd_y;
    res_next       = res;
    out_next       = out_data;
    out_valid_next = out_valid;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = addr;
    ram_wdata      = '0;

    // drop the result once taken
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == AW'(NUM_BINS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          is_read_next = (in_data.command == CMD_READ);
          sign_x_next  = in_data.comp_a[31];
          sign_y_next  = in_data.comp_b[31];
          mag_x_next   = in_data.comp_a[31] ? 32'(-in_data.comp_a) : in_data.comp_a;
          mag_y_next   = in_data.comp_b[31] ? 32'(-in_data.comp_b) : in_data.comp_b;
          mag_c_next   = in_data.comp_c[31] ? 32'(-in_data.comp_c) : in_data.comp_c;
          cnt_next     = 3'd0;
          sq_x_next    = 64'd0;
          if (in_data.command == CMD_READ) begin
            addr_next  = AW'(int'(rd_y) * BINS_X + int'(rd_x));
            state_next = ST_FETCH;
          end else if (projection_mode) begin
            state_next = ST_SQUARE;
          end else begin
            state_next = ST_INDEX;
          end
        end
      end

      // m^2, px^2, py^2, pz^2 through the multiplier, each scaled by 1/4
      ST_SQUARE: begin
        cnt_next = cnt + 3'd1;
        if (cnt != 3'd0) begin
          sq_x_next = sq_x + (prod >> 2);
        end
        if (cnt == 3'd4) begin
          sq_r_next   = 64'd0;
          sq_bit_next = 64'h4000_0000_0000_0000;
          step_next   = 6'd0;
          state_next  = ST_SQRT;
        end
      end

      // one root bit per cycle
      ST_SQRT: begin
        step_next   = step + 6'd1;
        sq_bit_next = sq_bit >> 2;
        if (sq_x >= sq_trial) begin
          sq_x_next = sq_x - sq_trial;
          sq_r_next = (sq_r >> 1) + sq_bit;
        end else begin
          sq_r_next = sq_r >> 1;
        end
        if (step == 6'd31) begin
          energy_next = sq_r_next[31:0];
          dv_num_next = {mag_x[31:0], 15'd0};
          dv_rem_next = 32'd0;
          dv_q_next   = 47'd0;
          dv_sel_next = 1'b0;
          step_next   = 6'd0;
          state_next  = ST_DIV;
        end
      end

      // one quotient bit per cycle: |p| * 2^15 / E
      ST_DIV: begin
        step_next   = step + 6'd1;
        dv_num_next = dv_num << 1;
        dv_q_next   = dv_q_fin;
        dv_rem_next = dv_ge ? 32'(dv_trial - {1'b0, energy}) : dv_trial[31:0];
        if (step == 6'd46) begin
          step_next = 6'd0;
          if (!dv_sel) begin
            mag_x_next  = vel_mag;
            dv_num_next = {mag_y[31:0], 15'd0};
            dv_rem_next = 32'd0;
            dv_q_next   = 47'd0;
            dv_sel_next = 1'b1;
          end else begin
            mag_y_next = vel_mag;
            cnt_next   = 3'd0;
            state_next = ST_INDEX;
          end
        end
      end

      // scale by reciprocal bin width, round half away from zero
      ST_INDEX: begin
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd1) begin
          idx_x_next = idx_new;
        end
        if (cnt == 3'd2) begin
          idx_y_next = idx_new;
          cnt_next   = 3'd0;
          state_next = ST_WINDOW;
        end
      end

      ST_WINDOW: begin
        res_next = '0;
        if (hit) begin
          addr_next  = AW'(int'(oy[YW:0]) * BINS_X + int'(ox[XW:0]));
          state_next = ST_FETCH;
        end else begin
          state_next = ST_DONE;
        end
      end

      // RAM registers the read this cycle
      ST_FETCH: begin
        state_next = ST_UPDATE;
      end

      ST_UPDATE: begin
        ram_we   = 1'b1;
        res_next = '0;
        if (is_read) begin
          ram_wdata          = '0;
          res_next.bin_value = ram_rdata;
          if (rd_y == YW'(BINS_Y - 1)) begin
            rd_y_next = '0;
            if (rd_x == XW'(BINS_X - 1)) begin
              rd_x_next         = '0;
              res_next.last_bin = 1'b1;
            end else begin
              rd_x_next = rd_x + 1'b1;
            end
          end else begin
            rd_y_next = rd_y + 1'b1;
          end
        end else begin
          ram_wdata          = bin_sum[BIN_W] ? '1 : bin_sum[BIN_W-1:0];
          res_next.in_window = 1'b1;
        end
        state_next = ST_DONE;
      end

      // hold until the output register frees up
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_next       = res;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      rd_x      <= '0;
      rd_y      <= '0;
      cnt       <= 3'd0;
      step      <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      rd_x      <= rd_x_next;
      rd_y      <= rd_y_next;
      cnt       <= cnt_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    is_read  <= is_read_next;
    mag_x    <= mag_x_next;
    mag_y    <= mag_y_next;
    mag_c    <= mag_c_next;
    sign_x   <= sign_x_next;
    sign_y   <= sign_y_next;
    sq_x     <= sq_x_next;
    sq_r     <= sq_r_next;
    sq_bit   <= sq_bit_next;
    energy   <= energy_next;
    dv_num   <= dv_num_next;
    dv_rem   <= dv_rem_next;
    dv_q     <= dv_q_next;
    dv_sel   <= dv_sel_next;
    idx_x    <= idx_x_next;
    idx_y    <= idx_y_next;
    addr     <= addr_next;
    res      <= res_next;
    out_data <= out_next;
  end

  h2d_ram #(
    .WIDTH (BIN_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (addr),
    .rd_data (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("request taken during clearing pass");

  a_hit_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_window |-> out_data.bin_value == '0 && !out_data.last_bin)
    else $error("accumulate result carries read fields");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && is_read && res_next.last_bin |=> rd_x == '0 && rd_y == '0)
    else $error("read pointer failed to wrap after final bin");

  a_write_only_update: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_UPDATE || state == ST_CLEAR)
    else $error("bin write outside update");

endmodule
`default_nettype wire

/* verif/tb_histogram_2d_binning_accumulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_2d_binning_accumulator
// Self-checking bench: particles and bin reads go in over the request channel,
// a local model of the binning and read-out predicts every result, and the
// result channel is compared field by field under random backpressure.
// ----------------------------------------------------------------------------
module tb_histogram_2d_binning_accumulator;
  import h2d_pkg::*;

  localparam int NBINS       = H2D_BINS_X * H2D_BINS_Y;
  localparam longint LIMIT   = 3000000;
  localparam longint BIN_TOP = 64'hFFFF_FFFF_FFFF;
  localparam int Q1          = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  h2d_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  h2d_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  histogram_2d_binning_accumulator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the block's registers and histogram
  logic               mdl_mode;
  logic [31:0]        mdl_mass, mdl_inv_x, mdl_inv_y, mdl_weight;
  logic signed [15:0] mdl_low_x, mdl_low_y;
  logic [47:0]        mdl_bins [NBINS];
  int                 mdl_rd_ptr;

  h2d_out_t expected_results[$];
  int  mismatches = 0;
  longint cycles = 0;
  bit  allow_idle = 1'b1;
  int  n_requests = 0, n_hits = 0, n_reads = 0, n_frames = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic longint unsigned abs64(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // round half away from zero after scaling by the reciprocal width
  function automatic longint bin_index(input longint proj, input logic [31:0] inv);
    longint unsigned m, idx;
    m = abs64(proj);
    if (m > 64'h8000_0000) m = 64'h8000_0000;
    idx = (m * longint'(inv) + 64'h8000_0000) >> 32;
    return proj < 0 ? -longint'(idx) : longint'(idx);
  endfunction

  function automatic longint speed(input longint p, input longint unsigned e);
    longint unsigned q;
    if (e == 0) return 0;  // zero energy: no velocity
    q = (abs64(p) << 15) / e;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return p < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void model_register(input int idx, input logic [31:0] val);
    case (idx)
      REG_MODE:   mdl_mode   = val[0];
      REG_MASS:   mdl_mass   = val;
      REG_INV_X:  mdl_inv_x  = val;
      REG_INV_Y:  mdl_inv_y  = val;
      REG_LOW_X:  mdl_low_x  = val[15:0];
      REG_LOW_Y:  mdl_low_y  = val[15:0];
      REG_WEIGHT: mdl_weight = val;
      default: ;
    endcase
  endfunction

  function automatic h2d_out_t bin_request(input h2d_in_t rq);
    h2d_out_t r;
    longint a, b, c, vx, vy, ox, oy;
    longint unsigned s, e, sum;
    int x, y, addr;
    r = '0;
    if (rq.command == CMD_READ) begin
      x = mdl_rd_ptr / H2D_BINS_Y;
      y = mdl_rd_ptr % H2D_BINS_Y;
      addr = y * H2D_BINS_X + x;
      r.bin_value = mdl_bins[addr];
      mdl_bins[addr] = '0;
      if (mdl_rd_ptr == NBINS - 1) begin
        r.last_bin = 1'b1;
        mdl_rd_ptr = 0;
      end else begin
        mdl_rd_ptr++;
      end
    end else begin
      a = rq.comp_a;
      b = rq.comp_b;
      c = rq.comp_c;
      if (mdl_mode) begin
        s = ((longint'(mdl_mass) * longint'(mdl_mass)) >> 2)
          + ((abs64(a) * abs64(a)) >> 2) + ((abs64(b) * abs64(b)) >> 2)
          + ((abs64(c) * abs64(c)) >> 2);
        e = int_sqrt(s);
        vx = speed(a, e);
        vy = speed(b, e);
      end else begin
        vx = a;
        vy = b;
      end
      ox = bin_index(vx, mdl_inv_x) - longint'(mdl_low_x);
      oy = bin_index(vy, mdl_inv_y) - longint'(mdl_low_y);
      if (ox > 0 && ox < H2D_BINS_X && oy > 0 && oy < H2D_BINS_Y) begin
        addr = int'(oy) * H2D_BINS_X + int'(ox);
        sum = longint'(mdl_bins[addr]) + longint'(mdl_weight);
        mdl_bins[addr] = sum > BIN_TOP ? BIN_TOP[47:0] : sum[47:0];
        r.in_window = 1'b1;
      end
    end
    return r;
  endfunction

  // Drive one request, hold it until accepted, then maybe idle a burst.
  task automatic send_request(input logic cmd, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c);
    h2d_in_t rq;
    h2d_out_t r;
    rq.command = cmd;
    rq.comp_a = a;
    rq.comp_b = b;
    rq.comp_c = c;
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
    r = bin_request(rq);
    expected_results.push_back(r);
    n_requests++;
    if (cmd == CMD_READ) begin
      n_reads++;
      if (r.last_bin) n_frames++;
    end else if (r.in_window) begin
      n_hits++;
    end
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic read_bin();
    send_request(CMD_READ, $urandom, $urandom, $urandom);
  endtask

  // Lower valid and wait until every result is back, plus settling time.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    model_register(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // return to idle between transfers
    @(posedge clk);
  endtask

  task automatic set_position_frame(input logic [31:0] inv, input logic [15:0] low,
                                    input logic [31:0] weight);
    drain_results();
    write_register(REG_MODE, 0);
    write_register(REG_INV_X, inv);
    write_register(REG_INV_Y, inv);
    write_register(REG_LOW_X, {{16{low[15]}}, low});
    write_register(REG_LOW_Y, {{16{low[15]}}, low});
    write_register(REG_WEIGHT, weight);
  endtask

  // Random coordinate: mostly within a few dozen bins of zero, sometimes anywhere.
  function automatic logic [31:0] near_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'(($urandom_range(0, 80) - 40) * Q1 + $urandom_range(0, Q1 - 1) - Q1 / 2);
  endfunction

  task automatic test_position_directed();
    // center, window edges on both sides, half-bin rounding, full range
    send_request(CMD_ACCUM, 0, 0, 32'hFFFF_FFFF);
    send_request(CMD_ACCUM, -31 * Q1, -31 * Q1, 0);
    send_request(CMD_ACCUM, -32 * Q1, 0, 0);
    send_request(CMD_ACCUM, 0, -32 * Q1, 0);
    send_request(CMD_ACCUM, 31 * Q1, 31 * Q1, 0);
    send_request(CMD_ACCUM, 32 * Q1, 5 * Q1, 0);
    send_request(CMD_ACCUM, 32'h0000_8000, 32'hFFFF_8000, 0);
    send_request(CMD_ACCUM, 32'h0000_7FFF, 32'hFFFF_8001, 0);
    send_request(CMD_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_ACCUM, 31 * Q1 + 32'h7FFF, -31 * Q1 - 32'h7FFF, 0);
    repeat (4) read_bin();
  endtask

  task automatic test_velocity_mode();
    drain_results();
    write_register(REG_MODE, 1);
    write_register(REG_INV_X, 30 * Q1);
    write_register(REG_INV_Y, 30 * Q1);
    write_register(REG_LOW_X, -32);
    write_register(REG_LOW_Y, -32);
    write_register(REG_MASS, 0);
    // zero energy, then a massless particle moving along each axis
    send_request(CMD_ACCUM, 0, 0, 0);
    send_request(CMD_ACCUM, Q1, 0, 0);
    send_request(CMD_ACCUM, 0, 32'h8000_0000, 0);
    send_request(CMD_ACCUM, 1, 1, 32'h7FFF_FFFF);
    drain_results();
    write_register(REG_MASS, 32'hFFFF_FFFF);
    send_request(CMD_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_ACCUM, 0, 0, 0);
    drain_results();
    write_register(REG_MASS, Q1);
    repeat (60) send_request(CMD_ACCUM, $urandom_range(0, 4 * Q1) - 2 * Q1,
                             $urandom_range(0, 4 * Q1) - 2 * Q1, $urandom);
    repeat (20) send_request(CMD_ACCUM, $urandom, $urandom, $urandom);
    repeat (10) read_bin();
  endtask

  task automatic test_register_extremes();
    // tiniest and largest widths, zero reciprocal width, window bounds at both ends
    set_position_frame(1, 16'sd0, 32'hFFFF_FFFF);
    write_register(7, 32'hDEAD_BEEF);  // beyond the register map: ignored
    send_request(CMD_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_request(CMD_ACCUM, 32'h8000_0000, 32'h8000_0000, 0);
    set_position_frame(32'hFFFF_FFFF, 16'sd0, Q1);
    send_request(CMD_ACCUM, 1, 1, 0);
    send_request(CMD_ACCUM, 32'h7FFF, 32'h8000, 0);
    send_request(CMD_ACCUM, 32'h3F, 32'h3E, 0);
    set_position_frame(0, 16'hFFFF, 3);
    send_request(CMD_ACCUM, $urandom, $urandom, $urandom);
    set_position_frame(Q1, 16'sh8000, 0);
    send_request(CMD_ACCUM, 32'h8000_0000, 32'h8000_0000, 0);
    set_position_frame(Q1, 16'sh7FFF, 1);
    send_request(CMD_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    set_position_frame(Q1, 16'sh7FC0, 5);
    send_request(CMD_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
  endtask

  task automatic test_random_mix();
    repeat (8) begin
      drain_results();
      write_register(REG_MODE, $urandom_range(0, 1));
      write_register(REG_MASS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2 * Q1));
      write_register(REG_INV_X, $urandom_range(0, 4) == 0 ? $urandom
                                : (mdl_mode ? $urandom_range(8, 40) * Q1
                                            : $urandom_range(Q1 / 2, 2 * Q1)));
      write_register(REG_INV_Y, $urandom_range(0, 4) == 0 ? $urandom
                                : (mdl_mode ? $urandom_range(8, 40) * Q1
                                            : $urandom_range(Q1 / 2, 2 * Q1)));
      write_register(REG_LOW_X, $urandom_range(0, 5) == 0 ? $urandom
                                : 32'($urandom_range(0, 40)) - 50);
      write_register(REG_LOW_Y, $urandom_range(0, 5) == 0 ? $urandom
                                : 32'($urandom_range(0, 40)) - 50);
      write_register(REG_WEIGHT, $urandom);
      repeat (60) begin
        if ($urandom_range(0, 4) == 0) read_bin();
        else if (mdl_mode) send_request(CMD_ACCUM, $urandom_range(0, 4 * Q1) - 2 * Q1,
                                        $urandom_range(0, 4 * Q1) - 2 * Q1, $urandom);
        else send_request(CMD_ACCUM, near_coord(), near_coord(), $urandom);
      end
    end
  endtask

  // Pile full-weight hits on one bin of the next column to be read, well past
  // 32 bits, then read forward until that bin comes back and is cleared.
  task automatic test_bin_growth();
    int col, reads;
    set_position_frame(Q1, -16'sd32, 32'hFFFF_FFFF);
    col = mdl_rd_ptr / H2D_BINS_Y + 1;
    repeat (40) send_request(CMD_ACCUM, 32'((col - 32) * Q1), -27 * Q1, 0);
    reads = col * H2D_BINS_Y + 5 - mdl_rd_ptr + 1;
    repeat (reads) read_bin();
  endtask

  // Result channel backpressure: bursts of stall, none in the last part
  int stall_left = 0;
  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      rdy = 1'b0;
      stall_left--;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      rdy = 1'b0;
      stall_left = $urandom_range(0, 3);
    end
    out_ready <= rdy;
  end

  // Compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    h2d_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_data.in_window !== want.in_window)
          report_mismatch($sformatf("in_window got %0b want %0b",
                                    out_data.in_window, want.in_window));
        if (out_data.bin_value !== want.bin_value)
          report_mismatch($sformatf("bin_value got %h want %h",
                                    out_data.bin_value, want.bin_value));
        if (out_data.last_bin !== want.last_bin)
          report_mismatch($sformatf("last_bin got %0b want %0b",
                                    out_data.last_bin, want.last_bin));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("tb_histogram_2d_binning_accumulator: FAIL");
      $finish;
    end
  end

  initial begin
    mdl_mode   = 1'b0;
    mdl_mass   = Q1;
    mdl_inv_x  = Q1;
    mdl_inv_y  = Q1;
    mdl_low_x  = -16'sd32;
    mdl_low_y  = -16'sd32;
    mdl_weight = Q1;
    mdl_rd_ptr = 0;
    foreach (mdl_bins[i]) mdl_bins[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_position_directed();
    test_velocity_mode();
    test_register_extremes();
    test_random_mix();
    allow_idle = 1'b0;
    test_bin_growth();

    drain_results();
    $display("covered %0d requests: %0d binned hits, %0d bin reads, %0d full frames",
             n_requests, n_hits, n_reads, n_frames);
    $display("both projection modes, register extremes, wide bin sums and read-clear");
    if (mismatches == 0) begin
      $display("tb_histogram_2d_binning_accumulator: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_histogram_2d_binning_accumulator: FAIL");
    end
    $finish;
  end

endmodule
